// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int MODE_W = 4;

  // Defaults for top-level parameters
  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Mode codes: operand pairing in the upper bits, operation in the lower bits
  localparam logic [MODE_W-1:0] MODE_FF_ADD = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FF_SUB = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FF_MUL = 4'd2;
  localparam logic [MODE_W-1:0] MODE_FF_DIV = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FI_ADD = 4'd4;
  localparam logic [MODE_W-1:0] MODE_FI_SUB = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FI_MUL = 4'd6;
  localparam logic [MODE_W-1:0] MODE_FI_DIV = 4'd7;
  localparam logic [MODE_W-1:0] MODE_IF_ADD = 4'd8;
  localparam logic [MODE_W-1:0] MODE_IF_SUB = 4'd9;
  localparam logic [MODE_W-1:0] MODE_IF_MUL = 4'd10;
  localparam logic [MODE_W-1:0] MODE_IF_DIV = 4'd11;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,   // low word of the product
    OP_MULF,  // product shifted down by the fraction width
    OP_DIV
  } op_e;

  // Queue entry. For OP_DIV, x and y hold operand magnitudes.
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic              scale;  // dividend is shifted up by the fraction width
    logic              neg;    // quotient is negated
    logic              dz;     // divisor is zero
  } entry_t;

endpackage

// ===== rtl/fpa_in_if.sv =====
interface fpa_in_if;
  logic                              valid;
  logic                              ready;
  logic        [fpa_pkg::MODE_W-1:0] mode;
  logic signed [fpa_pkg::DATA_W-1:0] operand_a;
  logic signed [fpa_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

// ===== rtl/fpa_out_if.sv =====
interface fpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpa_pkg::DATA_W-1:0] result;
  logic                              divide_by_zero;

  modport source (output valid, output result, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

// ===== rtl/fpa_front.sv =====
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fpa_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output fpa_pkg::entry_t push_data_o
);

  localparam int DW = fpa_pkg::DATA_W;

  logic            vld_q;
  fpa_pkg::entry_t ent_q;
  fpa_pkg::entry_t ent_d;
  logic            accept;

  logic [DW-1:0] a, b, a_sh, b_sh, mag_a, mag_b;

  // Holding register frees up whenever its beat moves into the queue
  assign in_i.ready   = !vld_q || push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = vld_q;
  assign push_data_o  = ent_q;

  // Operand preparation
  assign a     = in_i.operand_a;
  assign b     = in_i.operand_b;
  assign a_sh  = a << FRAC_BITS;
  assign b_sh  = b << FRAC_BITS;
  assign mag_a = a[DW-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DW-1] ? (~b + 1'b1) : b;

  // Classify the mode
  always_comb begin
    ent_d       = '0;
    ent_d.op    = fpa_pkg::OP_NONE;
    ent_d.x     = a;
    ent_d.y     = b;
    case (in_i.mode)
      fpa_pkg::MODE_FF_ADD: ent_d.op = fpa_pkg::OP_ADD;
      fpa_pkg::MODE_FF_SUB: ent_d.op = fpa_pkg::OP_SUB;
      fpa_pkg::MODE_FF_MUL: ent_d.op = fpa_pkg::OP_MULF;
      fpa_pkg::MODE_FI_ADD: begin
        ent_d.op = fpa_pkg::OP_ADD;
        ent_d.y  = b_sh;
      end
      fpa_pkg::MODE_FI_SUB: begin
        ent_d.op = fpa_pkg::OP_SUB;
        ent_d.y  = b_sh;
      end
      fpa_pkg::MODE_FI_MUL,
      fpa_pkg::MODE_IF_MUL: ent_d.op = fpa_pkg::OP_MUL;
      fpa_pkg::MODE_IF_ADD: begin
        ent_d.op = fpa_pkg::OP_ADD;
        ent_d.x  = a_sh;
      end
      fpa_pkg::MODE_IF_SUB: begin
        ent_d.op = fpa_pkg::OP_SUB;
        ent_d.x  = a_sh;
      end
      fpa_pkg::MODE_FF_DIV,
      fpa_pkg::MODE_FI_DIV,
      fpa_pkg::MODE_IF_DIV: begin
        ent_d.op    = fpa_pkg::OP_DIV;
        ent_d.x     = mag_a;
        ent_d.y     = mag_b;
        ent_d.scale = (in_i.mode != fpa_pkg::MODE_FI_DIV);
        ent_d.neg   = a[DW-1] ^ b[DW-1];
        ent_d.dz    = (b == '0);
      end
      default: ent_d.op = fpa_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== rtl/fpa_queue.sv =====
module fpa_queue #(
  parameter int DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fpa_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fpa_pkg::entry_t pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fpa_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Fill count
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count above depth");

endmodule

// ===== rtl/fpa_back.sv =====
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  fpa_pkg::entry_t pop_data_i,
  fpa_out_if.source       out_o
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int QW = DW + FRAC_BITS;  // quotient bits, one per stage
  localparam int NS = QW;

  // Pipeline registers
  logic [NS-1:0] vld_q, neg_q, dz_q, div_q;
  logic [QW-1:0] dvd_q [NS];
  logic [DW-1:0] rem_q [NS];
  logic [DW-1:0] dvs_q [NS];
  logic [DW-1:0] res_q [NS];

  logic          out_vld_q, out_dz_q;
  logic [DW-1:0] out_res_q;
  logic          en;

  // Whole pipeline advances unless the result register is blocked
  assign en          = !out_vld_q || out_o.ready;
  assign pop_ready_o = en;

  // Head: add/sub/multiply and dividend setup
  logic signed [2*DW-1:0] prod;
  logic        [DW-1:0]   res0;
  logic        [QW-1:0]   dvd0;
  logic                   is_div0;

  assign prod    = $signed(pop_data_i.x) * $signed(pop_data_i.y);
  assign dvd0    = pop_data_i.scale ? (QW'(pop_data_i.x) << FRAC_BITS) : QW'(pop_data_i.x);
  assign is_div0 = (pop_data_i.op == fpa_pkg::OP_DIV);

  always_comb begin
    case (pop_data_i.op)
      fpa_pkg::OP_ADD:  res0 = pop_data_i.x + pop_data_i.y;
      fpa_pkg::OP_SUB:  res0 = pop_data_i.x - pop_data_i.y;
      fpa_pkg::OP_MUL:  res0 = prod[DW-1:0];
      fpa_pkg::OP_MULF: res0 = prod[FRAC_BITS +: DW];
      default:          res0 = '0;
    endcase
  end

  // Restoring divide, one quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [QW-1:0] dvd_in;
    logic [DW-1:0] rem_in, dvs_in, res_in;
    logic          vld_in, neg_in, dz_in, div_in;
    logic [DW:0]   rem_ext, diff;
    logic          ge;

    if (i == 0) begin : g_head
      assign dvd_in = dvd0;
      assign rem_in = '0;
      assign dvs_in = pop_data_i.y;
      assign res_in = res0;
      assign vld_in = pop_valid_i;
      assign neg_in = pop_data_i.neg;
      assign dz_in  = pop_data_i.dz && is_div0;
      assign div_in = is_div0;
    end else begin : g_body
      assign dvd_in = dvd_q[i-1];
      assign rem_in = rem_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign res_in = res_q[i-1];
      assign vld_in = vld_q[i-1];
      assign neg_in = neg_q[i-1];
      assign dz_in  = dz_q[i-1];
      assign div_in = div_q[i-1];
    end

    assign rem_ext = {rem_in, dvd_in[QW-1]};
    assign diff    = rem_ext - {1'b0, dvs_in};
    assign ge      = ~diff[DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i] <= ge ? diff[DW-1:0] : rem_ext[DW-1:0];
        dvd_q[i] <= {dvd_in[QW-2:0], ge};
        dvs_q[i] <= dvs_in;
        res_q[i] <= res_in;
        neg_q[i] <= neg_in;
        dz_q[i]  <= dz_in;
        div_q[i] <= div_in;
      end
    end
  end

  // Result register: sign and zero-divisor fixup
  logic [DW-1:0] quo, res_fin;

  assign quo = dvd_q[NS-1][DW-1:0];

  always_comb begin
    if (!div_q[NS-1]) begin
      res_fin = res_q[NS-1];
    end else if (dz_q[NS-1]) begin
      res_fin = '0;
    end else if (neg_q[NS-1]) begin
      res_fin = ~quo + 1'b1;
    end else begin
      res_fin = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= res_fin;
      out_dz_q  <= dz_q[NS-1];
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.result         = out_res_q;
  assign out_o.divide_by_zero = out_dz_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_dz_q |-> out_res_q == '0)
    else $error("zero-divisor beat with nonzero result");

  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && dz_q[NS-1] |-> div_q[NS-1])
    else $error("zero-divisor flag on a non-divide beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q == $past(vld_q))
    else $error("pipeline moved while stalled");

endmodule

// ===== rtl/fixed_point_17_14_alu_unit.sv =====
// Signed fixed-point ALU (17.14 by default, FRAC_BITS fraction bits). Each
// input beat carries a mode (add, sub, mul, div for fixed/fixed, fixed/int and
// int/fixed) and two 32-bit operands; each gives one output beat with the
// result wrapped to 32 bits and a divide-by-zero flag (result 0 when set).
// Products round toward minus infinity, quotients truncate toward zero; modes
// 12..15 return 0. One beat is accepted per cycle unless an output stall has
// filled the queue and the front holding register. Beats pass that register,
// the queue, the divide pipeline (one quotient bit per stage, 32 + FRAC_BITS
// stages) and the output register; all modes travel through the same pipeline
// so results leave in order. A QUEUE_DEPTH-entry queue separates the
// classifying front end from the execution pipeline.
module fixed_point_17_14_alu_unit #(
  parameter int FRAC_BITS   = fpa_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);

  logic            fq_valid, fq_ready;
  fpa_pkg::entry_t fq_data;
  logic            qb_valid, qb_ready;
  fpa_pkg::entry_t qb_data;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (fq_valid),
    .push_ready_i (fq_ready),
    .push_data_o  (fq_data)
  );

  fpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (qb_valid),
    .pop_ready_o (qb_ready),
    .pop_data_i  (qb_data),
    .out_o       (out_o)
  );

endmodule
